>>> rtl/hse_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the hash set engine.
// No dependencies; every other file but hse_ram imports this package.
package hse_pkg;

	// Field widths of the stream items
	localparam int KEY_W  = 32;
	localparam int ACT_W  = 2;
	localparam int CNT_W  = 11;
	localparam int SLOT_W = KEY_W + 1;  // stored key plus its valid bit
	localparam int IN_W   = 40;         // action and key, padded to whole bytes
	localparam int OUT_W  = 16;         // was_present, status, entries_held, padded

	// Action codes; any other code acts as a lookup
	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

	// Outcome of one bucket visit
	typedef struct packed {
		logic hit;   // key found in the bucket
		logic full;  // insert refused, no free slot
		logic wr;    // row must be written back
		logic inc;   // one key added
		logic dec;   // one key removed
	} bkt_res_t;

endpackage

>>> rtl/hash_set_engine.sv
`timescale 1ns / 1ps
// Hash set engine: one item (lookup, insert, remove) at a time. The item passes
// the bucket index unit and the row read; the compare and write back then load the
// result, and wait while the previous result is still unread. The engine returns to
// idle before the next item is accepted. One item is in flight.
// Asynchronous active-low reset; after reset the bucket memory is swept clear,
// one row per cycle until every row is clear, and no item is accepted meanwhile.
// Depends on hse_pkg, hse_ram, hse_mod and hse_bucket.
module hash_set_engine
	import hse_pkg::*;
#(
	parameter int NUM_BUCKETS      = 256,
	parameter int SLOTS_PER_BUCKET = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [IN_W-1:0] s_tdata,   // [1:0] action, [33:2] key, [39:34] zero
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [OUT_W-1:0] m_tdata   // [0] was_present, [1] status,
	                                   // [12:2] entries_held, [15:13] zero
);

	localparam int AW    = $clog2(NUM_BUCKETS);
	localparam int ROW_W = SLOTS_PER_BUCKET * SLOT_W;
	localparam logic [AW-1:0] LAST_ROW = AW'(NUM_BUCKETS - 1);

	typedef enum logic [3:0] {
		ST_CLEAR  = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_MOD    = 4'b0100,
		ST_UPDATE = 4'b1000
	} state_t;

	state_t           state_q, state_d;
	logic [AW-1:0]    clr_q;
	logic [AW-1:0]    bkt_q;
	logic [ACT_W-1:0] action_q;
	logic [KEY_W-1:0] key_q;
	logic [CNT_W-1:0] cnt_q;
	logic             accept;
	logic             mod_valid;
	logic [AW-1:0]    mod_bucket;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [ROW_W-1:0] ram_wdata, ram_rdata, new_row;
	bkt_res_t         res;
	logic             out_free, finish;
	logic             m_tvalid_q;
	logic             present_q, status_q;
	logic [CNT_W-1:0] held_q;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign finish   = (state_q == ST_UPDATE) && out_free;

	// Bucket index of the accepted key
	hse_mod #(
		.NUM_BUCKETS(NUM_BUCKETS)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.in_key    (s_tdata[KEY_W+ACT_W-1:ACT_W]),
		.out_valid (mod_valid),
		.out_bucket(mod_bucket)
	);

	// Bucket rows: key and valid bit of every slot
	assign ram_we    = (state_q == ST_CLEAR) || (finish && res.wr);
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : bkt_q;
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : new_row;

	hse_ram #(
		.WIDTH(ROW_W),
		.DEPTH(NUM_BUCKETS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (mod_valid),
		.raddr(mod_bucket),
		.rdata(ram_rdata)
	);

	// Compare and modify the row read back
	hse_bucket #(
		.SLOTS(SLOTS_PER_BUCKET)
	) u_bucket (
		.action (action_q),
		.key    (key_q),
		.row    (ram_rdata),
		.res    (res),
		.new_row(new_row)
	);

	// Sequence one item at a time
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_ROW) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) state_d = ST_MOD;
			end
			ST_MOD: begin
				if (mod_valid) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	// Hold the item and its bucket
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= s_tdata[ACT_W-1:0];
			key_q    <= s_tdata[KEY_W+ACT_W-1:ACT_W];
		end
		if (mod_valid) begin
			bkt_q <= mod_bucket;
		end
	end

	// Track the number of keys held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (finish) begin
			if (res.inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (res.dec) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			present_q <= res.hit;
			status_q  <= res.full;
			if (res.inc) begin
				held_q <= cnt_q + CNT_W'(1);
			end else if (res.dec) begin
				held_q <= cnt_q - CNT_W'(1);
			end else begin
				held_q <= cnt_q;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(OUT_W-CNT_W-2)'(0), held_q, status_q, present_q};

	// A result appears only after the update state
	a_out_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_UPDATE))
		else $error("result appeared without a row update");

	// The index unit answers only for the item in flight
	a_mod_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		mod_valid |-> (state_q == ST_MOD))
		else $error("bucket index outside of an item");

	// The key count moves by at most one per item
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + CNT_W'(1)) ||
		(cnt_q == $past(cnt_q) - CNT_W'(1)))
		else $error("key count jumped");

	// The key count changes only as its result is loaded
	a_cnt_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |-> (m_tvalid_q && (held_q == cnt_q)))
		else $error("key count changed without a result");

endmodule

>>> rtl/hse_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module hse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/hse_mod.sv
`timescale 1ns / 1ps
// Bucket index unit: key modulo NUM_BUCKETS in three pipeline stages,
// by reciprocal multiply, back multiply and one correction. Depends on hse_pkg.
module hse_mod
	import hse_pkg::*;
#(
	parameter int NUM_BUCKETS = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [KEY_W-1:0]               in_key,
	output logic                           out_valid,
	output logic [$clog2(NUM_BUCKETS)-1:0] out_bucket
);

	localparam int          LOG_NB = $clog2(NUM_BUCKETS);
	localparam int          SHIFT  = 31 + LOG_NB;
	// floor(2^SHIFT / N) lies in [2^31, 2^32); the quotient estimate is q or q-1
	localparam logic [63:0] RECIP64 = (64'd1 << SHIFT) / 64'(NUM_BUCKETS);
	localparam logic [31:0] RECIP   = RECIP64[31:0];
	localparam logic [31:0] NB32    = 32'(NUM_BUCKETS);
	localparam logic [LOG_NB:0] NB_R = (LOG_NB+1)'(NUM_BUCKETS);

	logic              v_s1, v_s2, v_s3;
	logic [KEY_W-1:0]  key_s1, key_s2;
	logic [31:0]       q_s1;
	logic [31:0]       qn_s2;
	logic [LOG_NB-1:0] bucket_s3;
	logic [63:0]       prod1, prod2;
	logic [31:0]       diff;
	logic [LOG_NB:0]   rem_raw;
	logic [LOG_NB:0]   rem_fix;

	assign prod1 = {32'b0, in_key} * {32'b0, RECIP};
	assign prod2 = {32'b0, q_s1} * {32'b0, NB32};
	assign diff  = key_s2 - qn_s2;
	assign rem_raw = diff[LOG_NB:0];
	assign rem_fix = (rem_raw >= NB_R) ? (rem_raw - NB_R) : rem_raw;

	// Advance the valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: quotient estimate; stage 2: estimate times N; stage 3: remainder
	always_ff @(posedge clk) begin
		key_s1    <= in_key;
		q_s1      <= 32'(prod1 >> SHIFT);
		key_s2    <= key_s1;
		qn_s2     <= prod2[31:0];
		bucket_s3 <= rem_fix[LOG_NB-1:0];
	end

	assign out_valid  = v_s3;
	assign out_bucket = bucket_s3;

endmodule

>>> rtl/hse_bucket.sv
`timescale 1ns / 1ps
// Bucket row logic: compares all slots of one row at once and builds the
// row to write back for an insert or a remove. Depends on hse_pkg.
module hse_bucket
	import hse_pkg::*;
#(
	parameter int SLOTS = 4
) (
	input  logic [ACT_W-1:0]        action,
	input  logic [KEY_W-1:0]        key,
	input  logic [SLOTS*SLOT_W-1:0] row,
	output bkt_res_t                res,
	output logic [SLOTS*SLOT_W-1:0] new_row
);

	logic [SLOTS-1:0] valid_v, match_v, hit_oh, free_oh;
	logic             hit, has_free, is_ins, is_rem, do_ins, do_rem;

	// Compare every slot of the row
	always_comb begin
		for (int s = 0; s < SLOTS; s++) begin
			valid_v[s] = row[s*SLOT_W + KEY_W];
			match_v[s] = valid_v[s] && (row[s*SLOT_W +: KEY_W] == key);
		end
	end

	// Pick the lowest matching slot and the lowest free slot
	assign hit_oh   = match_v & (~match_v + SLOTS'(1));
	assign free_oh  = ~valid_v & (valid_v + SLOTS'(1));
	assign hit      = |match_v;
	assign has_free = |(~valid_v);

	assign is_ins = (action == ACT_INSERT);
	assign is_rem = (action == ACT_REMOVE);
	assign do_ins = is_ins && !hit && has_free;
	assign do_rem = is_rem && hit;

	assign res.hit  = hit;
	assign res.full = is_ins && !hit && !has_free;
	assign res.wr   = do_ins || do_rem;
	assign res.inc  = do_ins;
	assign res.dec  = do_rem;

	// Place the key in the free slot, or drop the valid bit of the hit
	always_comb begin
		new_row = row;
		for (int s = 0; s < SLOTS; s++) begin
			if (do_ins && free_oh[s]) begin
				new_row[s*SLOT_W +: SLOT_W] = {1'b1, key};
			end
			if (do_rem && hit_oh[s]) begin
				new_row[s*SLOT_W + KEY_W] = 1'b0;
			end
		end
	end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for hash_set_engine: lookups, inserts and removes of 32-bit keys,
// checked against a behavioral copy of the bucketed key store.
// Depends on hse_pkg and rtl/hash_set_engine.sv.
module tb_top
	import hse_pkg::*;
();

	localparam int NUM_BUCKETS      = 256;
	localparam int SLOTS_PER_BUCKET = 4;
	localparam int LONG_HOLD        = 80;
	localparam int RANDOM_ITEMS     = 1330;

	localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
	localparam logic [ACT_W-1:0] ACT_SPARE  = 2'd3;  // unused code, behaves as lookup

	// Behavioral copy of the key store; holds the replies still owed by the block
	class set_tracker #(int BUCKETS = 256, int SLOTS = 4);
		typedef struct {
			bit         was_present;
			bit         refused;
			logic [10:0] held;
		} reply_t;

		bit [31:0] slot_key  [BUCKETS*SLOTS];
		bit        slot_used [BUCKETS*SLOTS];
		int        key_total;
		reply_t    expected_replies[$];
		int        mismatches;
		int        replies;

		function int pending();
			return expected_replies.size();
		endfunction

		// Apply one accepted request to the store and queue the reply it must produce
		function void note_request(logic [1:0] act, logic [31:0] key);
			int     base;
			int     hit;
			int     free_idx;
			reply_t r;
			base     = int'(key % 32'(BUCKETS)) * SLOTS;
			hit      = -1;
			free_idx = -1;
			r.refused = 1'b0;
			for (int s = 0; s < SLOTS; s++) begin
				if (slot_used[base+s]) begin
					if (hit < 0 && slot_key[base+s] == key) hit = base + s;
				end else if (free_idx < 0) begin
					free_idx = base + s;
				end
			end
			case (act)
				ACT_INSERT: begin
					if (hit < 0) begin
						if (free_idx < 0) begin
							r.refused = 1'b1;
						end else begin
							slot_key[free_idx]  = key;
							slot_used[free_idx] = 1'b1;
							key_total++;
						end
					end
				end
				ACT_REMOVE: begin
					if (hit >= 0) begin
						slot_used[hit] = 1'b0;
						key_total--;
					end
				end
				default: ;
			endcase
			r.was_present = (hit >= 0);
			r.held        = key_total[10:0];
			expected_replies.push_back(r);
		endfunction

		task report_mismatch(string what, int unsigned want, logic [31:0] got);
			mismatches++;
			if (mismatches <= 100)
				$display("mismatch on reply %0d: %s expected %0d got %0d", replies, what,
					want, got);
		endtask

		// Compare one accepted reply with the oldest one owed
		task check_reply(logic [OUT_W-1:0] word);
			reply_t want;
			replies++;
			if (expected_replies.size() == 0) begin
				report_mismatch("reply with nothing owed, word", 0, 32'(word));
				return;
			end
			want = expected_replies.pop_front();
			if (word[0] !== want.was_present)
				report_mismatch("was_present", want.was_present, 32'(word[0]));
			if (word[1] !== want.refused)
				report_mismatch("status", want.refused, 32'(word[1]));
			if (word[12:2] !== want.held)
				report_mismatch("entries_held", want.held, 32'(word[12:2]));
		endtask
	endclass

	typedef set_tracker #(NUM_BUCKETS, SLOTS_PER_BUCKET) tracker_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;

	tracker_t sb = new();

	bit        idle_on;
	bit        hold_req;
	bit [23:0] tag_pool [8];
	bit [7:0]  hot_bucket [6] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};

	always #5 clk = ~clk;

	hash_set_engine #(
		.NUM_BUCKETS     (NUM_BUCKETS),
		.SLOTS_PER_BUCKET(SLOTS_PER_BUCKET)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	// Offer one item from a falling edge and hold it until accepted
	task automatic send_item(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_W-KEY_W-ACT_W){1'b0}}, key, act};
		do @(posedge clk); while (!s_tready);
		sb.note_request(act, key);
		@(negedge clk);
	endtask

	// Withdraw the offer and hold off new items until every owed reply has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	// Random request: mostly keys that crowd a few buckets, so buckets fill and hit
	task automatic send_random();
		logic [KEY_W-1:0] key;
		logic [ACT_W-1:0] act;
		int               r;
		r = $urandom_range(0, 99);
		if (r < 60)
			key = {tag_pool[$urandom_range(0, 7)], hot_bucket[$urandom_range(0, 5)]};
		else if (r < 85)
			key = {tag_pool[$urandom_range(0, 7)], 8'($urandom_range(0, 255))};
		else
			key = $urandom;
		r = $urandom_range(0, 99);
		if (r < 45)      act = ACT_INSERT;
		else if (r < 75) act = ACT_REMOVE;
		else if (r < 93) act = ACT_LOOKUP;
		else             act = ACT_SPARE;
		send_item(act, key);
	endtask

	// Receiver: random short stalls, one long hold on request
	initial begin
		int rx_gap;
		rx_gap   = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else if (rx_gap > 0) begin
				m_tready <= 1'b0;
				rx_gap--;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				rx_gap = $urandom_range(0, 2);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Check every accepted reply
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_reply(m_tdata);
	end

	// Stimulus
	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		hold_req = 1'b0;
		idle_on  = 1'b1;
		foreach (tag_pool[i]) tag_pool[i] = 24'($urandom);
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Directed: empty store, duplicates, a full bucket, extreme keys, spare code
		send_item(ACT_LOOKUP, 32'h0000_0000);
		send_item(ACT_INSERT, 32'h0000_0000);
		send_item(ACT_INSERT, 32'h0000_0000);
		send_item(ACT_LOOKUP, 32'h0000_0000);
		send_item(ACT_INSERT, 32'hFFFF_FFFF);
		send_item(ACT_SPARE,  32'hFFFF_FFFF);
		send_item(ACT_REMOVE, 32'h1234_5678);
		send_item(ACT_INSERT, 32'h0000_0100);
		send_item(ACT_INSERT, 32'h0000_0200);
		send_item(ACT_INSERT, 32'h0000_0300);
		send_item(ACT_INSERT, 32'h0000_0400);
		send_item(ACT_LOOKUP, 32'h0000_0400);
		send_item(ACT_REMOVE, 32'h0000_0200);
		send_item(ACT_INSERT, 32'h0000_0400);
		send_item(ACT_LOOKUP, 32'h0000_0200);
		send_item(ACT_INSERT, 32'h0000_0300);
		send_item(ACT_REMOVE, 32'h0000_0000);
		send_item(ACT_REMOVE, 32'h0000_0000);
		send_item(ACT_INSERT, 32'hAAAA_AAAA);
		send_item(ACT_INSERT, 32'h5555_5555);
		send_item(ACT_SPARE,  32'h5555_5555);
		send_item(ACT_REMOVE, 32'hFFFF_FFFF);
		send_item(ACT_LOOKUP, 32'hAAAA_AAAA);

		// Random traffic with a long receiver hold, a full pause and quiet stretches
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 300)  hold_req = 1'b1;
			if (i == 600)  drain();
			if (i == 700)  idle_on = 1'b0;
			if (i == 850)  idle_on = 1'b1;
			if (i == 1030) idle_on = 1'b0;
			send_random();
		end

		drain();
		repeat (10) @(negedge clk);
		if (sb.mismatches == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#4_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule
